### design/single_source_shortest_path_defines.svh
// ---------------------------------------------------------------------------
// Shortest path engine: assertion macros
// Shared concurrent assertion forms for the checker.
// ---------------------------------------------------------------------------
`ifndef SINGLE_SOURCE_SHORTEST_PATH_DEFINES_SVH
`define SINGLE_SOURCE_SHORTEST_PATH_DEFINES_SVH

// same-cycle implication, masked while in reset
`define SSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, masked while in reset
`define SSP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also spans the reset itself
`define SSP_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### design/ssp_pkg.sv
// ---------------------------------------------------------------------------
// Shortest path engine package
// Sizes, limits and action codes.
// ---------------------------------------------------------------------------
package ssp_pkg;
  localparam int SSP_MAX_VERTICES = 16;
  localparam int SSP_WEIGHT_BITS  = 16;
  localparam int SSP_DIST_BITS    = 20;
  localparam int SSP_RESULT_CAP   = 16;

  localparam logic [4:0] SSP_VC_RESET = 5'd16;

  typedef logic [1:0] ssp_action_t;
  localparam ssp_action_t ACT_CLEAR  = 2'd0;
  localparam ssp_action_t ACT_INSERT = 2'd1;
  localparam ssp_action_t ACT_RUN    = 2'd2;
endpackage

### design/ssp_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module ssp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### design/single_source_shortest_path.sv
// ---------------------------------------------------------------------------
// Single-source shortest path engine
// Dense Dijkstra over an arc store held in RAM, one result per vertex.
// ---------------------------------------------------------------------------
// Channel  | Dir | Carries
// in_*     | in  | tuser: action; tdata: from_vertex, to_vertex, arc_weight
// out_*    | out | tuser: reachable; tlast: last; tdata: vertex, distance, predecessor
// cfg_*    | in  | tdata: vertex_count (5 bits)
//
// Reset runs a clearing pass over the arc store, one entry a cycle; no input
// transaction is taken meanwhile, though config is. A clear action repeats
// that pass. An insert reads the stored arc, then writes the lighter weight.
// A run alternates relaxation and search rounds, one per vertex settled, each
// set by one arc read and one distance read a cycle, then emits each result
// through the read, load and hold states, holding while the output stalls.
// One item is in flight at a time.
// ---------------------------------------------------------------------------
module single_source_shortest_path import ssp_pkg::*; #(
  parameter int MAX_VERTICES = SSP_MAX_VERTICES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // action
  input  logic [23:0] in_tdata,   // from_vertex[3:0], to_vertex[7:4], arc_weight[23:8]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic        out_tuser,  // reachable
  output logic        out_tlast,
  output logic [31:0] out_tdata,  // vertex[3:0], distance[23:4], predecessor[27:24]
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [7:0]  cfg_tdata   // vertex_count[4:0]
);
  localparam int VW   = $clog2(MAX_VERTICES);
  localparam int CW   = VW + 1;
  localparam int AAW  = 2 * VW;
  localparam int ADEP = 1 << AAW;
  localparam int WB   = SSP_WEIGHT_BITS;
  localparam int DW   = SSP_DIST_BITS;
  localparam int NCAP = (MAX_VERTICES < SSP_RESULT_CAP) ? MAX_VERTICES : SSP_RESULT_CAP;

  localparam logic [3:0] ST_CLR      = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_INS      = 4'd2;
  localparam logic [3:0] ST_RELAX    = 4'd3;
  localparam logic [3:0] ST_FIND     = 4'd4;
  localparam logic [3:0] ST_OUT_RD   = 4'd5;
  localparam logic [3:0] ST_OUT_LD   = 4'd6;
  localparam logic [3:0] ST_OUT_HOLD = 4'd7;

  localparam logic [DW-1:0] DMAX = {DW{1'b1}};

  // control state
  logic [3:0]              state_r, state_nxt;
  logic [AAW-1:0]          clr_r, clr_nxt;
  logic [CW-1:0]           j_r, j_nxt;
  logic                    pv_r, pv_nxt;
  logic [VW-1:0]           pj_r, pj_nxt;
  logic [VW-1:0]           k_r, k_nxt;
  logic [DW-1:0]           dk_r, dk_nxt;
  logic [MAX_VERTICES-1:0] reached_r, reached_nxt;
  logic [MAX_VERTICES-1:0] settled_r, settled_nxt;
  logic                    found_r, found_nxt;
  logic [VW-1:0]           bk_r, bk_nxt;
  logic [DW-1:0]           best_r, best_nxt;
  logic [4:0]              vc_r, vc_nxt;
  logic                    ov_r, ov_nxt;
  // payload
  logic [VW-1:0]           if_r, if_nxt;
  logic [VW-1:0]           it_r, it_nxt;
  logic [WB-1:0]           iw_r, iw_nxt;
  logic [3:0]              ovx_r, ovx_nxt;
  logic [DW-1:0]           od_r, od_nxt;
  logic [3:0]              op_r, op_nxt;
  logic                    or_r, or_nxt;
  logic                    ol_r, ol_nxt;

  // memory ports
  logic           arc_we;
  logic [AAW-1:0] arc_waddr, arc_raddr;
  logic [WB:0]    arc_wdata, arc_rdata;
  logic           dst_we;
  logic [VW-1:0]  dst_waddr, dst_raddr;
  logic [VW+DW-1:0] dst_wdata, dst_rdata;

  logic [CW-1:0]  n_act;
  logic [3:0]     in_from, in_to;
  logic [WB-1:0]  in_w;
  logic [DW:0]    sum_w;
  logic [DW-1:0]  sum_sat;

  assign in_from = in_tdata[3:0];
  assign in_to   = in_tdata[7:4];
  assign in_w    = in_tdata[23:8];

  ssp_ram #(.WIDTH(WB + 1), .DEPTH(ADEP)) u_arc (
    .clk, .we(arc_we), .waddr(arc_waddr), .wdata(arc_wdata),
    .raddr(arc_raddr), .rdata(arc_rdata)
  );

  // distance and predecessor per vertex, {pred, dist}
  ssp_ram #(.WIDTH(VW + DW), .DEPTH(MAX_VERTICES)) u_dist (
    .clk, .we(dst_we), .waddr(dst_waddr), .wdata(dst_wdata),
    .raddr(dst_raddr), .rdata(dst_rdata)
  );

  // vertices in use: zero acts as one, clamp to the limit
  always_comb begin
    if (vc_r == 5'd0) begin
      n_act = CW'(1);
    end else if (32'(vc_r) > NCAP) begin
      n_act = CW'(NCAP);
    end else begin
      n_act = CW'(vc_r);
    end
  end

  // saturating relaxation sum
  assign sum_w   = {1'b0, dk_r} + (DW + 1)'(arc_rdata[WB-1:0]);
  assign sum_sat = sum_w[DW] ? DMAX : sum_w[DW-1:0];

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_tready = 1'b1;
  assign out_tvalid = ov_r;
  assign out_tuser  = or_r;
  assign out_tlast  = ol_r;
  assign out_tdata  = {4'd0, op_r, od_r, ovx_r};

  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    j_nxt       = j_r;
    pv_nxt      = pv_r;
    pj_nxt      = pj_r;
    k_nxt       = k_r;
    dk_nxt      = dk_r;
    reached_nxt = reached_r;
    settled_nxt = settled_r;
    found_nxt   = found_r;
    bk_nxt      = bk_r;
    best_nxt    = best_r;
    vc_nxt      = vc_r;
    ov_nxt      = ov_r;
    if_nxt      = if_r;
    it_nxt      = it_r;
    iw_nxt      = iw_r;
    ovx_nxt     = ovx_r;
    od_nxt      = od_r;
    op_nxt      = op_r;
    or_nxt      = or_r;
    ol_nxt      = ol_r;
    arc_we      = 1'b0;
    arc_waddr   = clr_r;
    arc_wdata   = '0;
    arc_raddr   = {k_r, j_r[VW-1:0]};
    dst_we      = 1'b0;
    dst_waddr   = pj_r;
    dst_wdata   = {k_r, sum_sat};
    dst_raddr   = j_r[VW-1:0];

    if (cfg_tvalid) begin
      vc_nxt = cfg_tdata[4:0];
    end

    case (state_r)
      ST_CLR: begin
        // sweep the arc store, one entry a cycle
        arc_we  = 1'b1;
        clr_nxt = clr_r + AAW'(1);
        if (clr_r == AAW'(ADEP - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          case (in_tuser)
            ACT_CLEAR: begin
              clr_nxt   = '0;
              state_nxt = ST_CLR;
            end
            ACT_INSERT: begin
              if (32'(in_from) < MAX_VERTICES && 32'(in_to) < MAX_VERTICES) begin
                if_nxt    = VW'(in_from);
                it_nxt    = VW'(in_to);
                iw_nxt    = in_w;
                arc_raddr = {VW'(in_from), VW'(in_to)};
                state_nxt = ST_INS;
              end
            end
            ACT_RUN: begin
              reached_nxt = '0;
              settled_nxt = '0;
              j_nxt       = '0;
              pv_nxt      = 1'b0;
              if (32'(in_from) < 32'(n_act)) begin
                // seed the source and relax its arcs
                k_nxt                       = VW'(in_from);
                dk_nxt                      = '0;
                reached_nxt[VW'(in_from)]   = 1'b1;
                settled_nxt[VW'(in_from)]   = 1'b1;
                dst_we                      = 1'b1;
                dst_waddr                   = VW'(in_from);
                dst_wdata                   = {VW'(in_from), {DW{1'b0}}};
                state_nxt                   = ST_RELAX;
              end else begin
                state_nxt = ST_OUT_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_INS: begin
        // keep the lighter of a repeated arc
        if (!arc_rdata[WB] || iw_r < arc_rdata[WB-1:0]) begin
          arc_we    = 1'b1;
          arc_waddr = {if_r, it_r};
          arc_wdata = {1'b1, iw_r};
        end
        state_nxt = ST_IDLE;
      end
      ST_RELAX: begin
        pv_nxt = 1'b0;
        if (j_r < n_act) begin
          j_nxt  = j_r + CW'(1);
          pv_nxt = 1'b1;
          pj_nxt = j_r[VW-1:0];
        end
        if (pv_r) begin
          if (arc_rdata[WB] && !settled_r[pj_r] &&
              (!reached_r[pj_r] || sum_sat < dst_rdata[DW-1:0])) begin
            dst_we             = 1'b1;
            reached_nxt[pj_r]  = 1'b1;
          end
        end else if (j_r == n_act) begin
          j_nxt     = '0;
          found_nxt = 1'b0;
          state_nxt = ST_FIND;
        end
      end
      ST_FIND: begin
        pv_nxt = 1'b0;
        if (j_r < n_act) begin
          j_nxt  = j_r + CW'(1);
          pv_nxt = 1'b1;
          pj_nxt = j_r[VW-1:0];
        end
        if (pv_r) begin
          // strict compare keeps the lowest index on ties
          if (reached_r[pj_r] && !settled_r[pj_r] &&
              (!found_r || dst_rdata[DW-1:0] < best_r)) begin
            found_nxt = 1'b1;
            bk_nxt    = pj_r;
            best_nxt  = dst_rdata[DW-1:0];
          end
        end else if (j_r == n_act) begin
          j_nxt = '0;
          if (found_r) begin
            settled_nxt[bk_r] = 1'b1;
            k_nxt             = bk_r;
            dk_nxt            = best_r;
            state_nxt         = ST_RELAX;
          end else begin
            state_nxt = ST_OUT_RD;
          end
        end
      end
      ST_OUT_RD: begin
        state_nxt = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        ovx_nxt   = 4'(j_r);
        or_nxt    = reached_r[j_r[VW-1:0]];
        od_nxt    = reached_r[j_r[VW-1:0]] ? dst_rdata[DW-1:0] : DMAX;
        op_nxt    = reached_r[j_r[VW-1:0]] ? 4'(dst_rdata[VW+DW-1:DW]) : 4'd0;
        ol_nxt    = (j_r + CW'(1) == n_act);
        ov_nxt    = 1'b1;
        state_nxt = ST_OUT_HOLD;
      end
      ST_OUT_HOLD: begin
        // hold the result until the sink takes it
        if (out_tready) begin
          ov_nxt = 1'b0;
          if (ol_r) begin
            state_nxt = ST_IDLE;
          end else begin
            j_nxt     = j_r + CW'(1);
            state_nxt = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLR;
      clr_r     <= '0;
      j_r       <= '0;
      pv_r      <= 1'b0;
      pj_r      <= '0;
      k_r       <= '0;
      dk_r      <= '0;
      reached_r <= '0;
      settled_r <= '0;
      found_r   <= 1'b0;
      bk_r      <= '0;
      best_r    <= '0;
      vc_r      <= SSP_VC_RESET;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      j_r       <= j_nxt;
      pv_r      <= pv_nxt;
      pj_r      <= pj_nxt;
      k_r       <= k_nxt;
      dk_r      <= dk_nxt;
      reached_r <= reached_nxt;
      settled_r <= settled_nxt;
      found_r   <= found_nxt;
      bk_r      <= bk_nxt;
      best_r    <= best_nxt;
      vc_r      <= vc_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if_r  <= if_nxt;
    it_r  <= it_nxt;
    iw_r  <= iw_nxt;
    ovx_r <= ovx_nxt;
    od_r  <= od_nxt;
    op_r  <= op_nxt;
    or_r  <= or_nxt;
    ol_r  <= ol_nxt;
  end
endmodule

### design/ssp_checker.sv
// ---------------------------------------------------------------------------
// Shortest path engine port checker
// Watches the top-level ports over time; bound to the top level.
// ---------------------------------------------------------------------------
`include "single_source_shortest_path_defines.svh"

module ssp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic [23:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic        out_tuser,
  input logic        out_tlast,
  input logic [31:0] out_tdata,
  input logic        cfg_tvalid,
  input logic        cfg_tready,
  input logic [7:0]  cfg_tdata
);
  `SSP_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")
  `SSP_ASSERT_IMP(a_one_item, in_tready, !out_tvalid, "input taken while a result waits")
  `SSP_ASSERT_RST(a_rst_clear, !rst_n, !in_tready, "input taken during clearing pass")
  `SSP_ASSERT_NXT(a_run_end, out_tvalid && out_tready && out_tlast, !out_tvalid, "result after end of run")
endmodule

bind single_source_shortest_path ssp_checker u_ssp_checker (.*);
